>>> sv/tqd_pkg.sv
// Shared types, codes and field widths of the task queue dispatcher.
package tqd_pkg;

    localparam int WORKER_W = 3;
    localparam int TASK_W   = 32;
    localparam int STATUS_W = 3;
    localparam int CFG_W    = 4;

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 4'd8;

    localparam logic MODE_SUBMIT  = 1'b0;
    localparam logic MODE_REQUEST = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_QUEUED     = 3'd0,
        ST_OVERFLOW   = 3'd1,
        ST_DELIVERED  = 3'd2,
        ST_IDLE       = 3'd3,
        ST_BAD_WORKER = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        FSM_READY,
        FSM_SCAN,
        FSM_READ,
        FSM_DONE
    } fsm_t;

endpackage

>>> sv/tqd_if.sv
// Request and result channel interfaces of the task queue dispatcher.
interface tqd_req_if;
    logic                            valid;
    logic                            ready;
    logic                            mode;
    logic [tqd_pkg::WORKER_W-1:0]    worker_id;
    logic [tqd_pkg::TASK_W-1:0]      task_payload;

    modport source (output valid, output mode, output worker_id, output task_payload,
                    input ready);
    modport sink (input valid, input mode, input worker_id, input task_payload,
                  output ready);
endinterface

interface tqd_rsp_if;
    logic                            valid;
    logic                            ready;
    tqd_pkg::status_t                status;
    logic [tqd_pkg::WORKER_W-1:0]    queue_index;
    logic [tqd_pkg::TASK_W-1:0]      task_out;
    logic                            stolen;

    modport source (output valid, output status, output queue_index, output task_out,
                    output stolen, input ready);
    modport sink (input valid, input status, input queue_index, input task_out,
                  input stolen, output ready);
endinterface

>>> sv/tqd_ram.sv
// Generic single-port RAM with registered read data.
module tqd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

>>> sv/task_queue_dispatch_steal.sv
// Top level of the work-stealing task queue dispatcher.
//
// Usage: one ring FIFO of task words per worker, all held in one RAM.
// The req channel carries a submit (mode 0, task_payload) or a worker
// request (mode 1, worker_id). Each request yields exactly one item on the
// rsp channel: status, queue_index, task_out and stolen.
// A submit goes to the active queue with the fewest entries (lowest index on
// ties); a worker request pops its own queue or steals from the next
// non-empty active queue upward with wrap-around.
// cfg_we/cfg_wdata write active_workers; write only while the block is idle.
// The fill counts are scanned one queue per cycle. A submit scans all N
// active queues before its result (N = active count); a worker request
// scans up to the first non-empty queue and then reads the RAM; an idle
// request scans all N. A bad worker skips the scan. The block holds one
// request at a time; the next is accepted the cycle after the result moves
// into the output register.
// Reset clears all pointers and fill counts and sets active_workers to 8;
// the RAM is not cleared. When rsp stalls the output register holds its
// result; one further request may be accepted and finished, then waits.
module task_queue_dispatch_steal #(
    parameter int QUEUE_DEPTH   = 64,
    parameter int MAX_WORKERS   = 8,
    parameter int PAYLOAD_WIDTH = 32
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [tqd_pkg::CFG_W-1:0] cfg_wdata,
    tqd_req_if.sink                   req,
    tqd_rsp_if.source                 rsp
);

    localparam int SW = (PAYLOAD_WIDTH < tqd_pkg::TASK_W) ? PAYLOAD_WIDTH : tqd_pkg::TASK_W;
    localparam int QW = $clog2(MAX_WORKERS);
    localparam int NW = $clog2(MAX_WORKERS + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);
    localparam int RAM_DEPTH = MAX_WORKERS * QUEUE_DEPTH;
    localparam int AW = $clog2(RAM_DEPTH);

    tqd_pkg::fsm_t    state_reg, state_next;
    tqd_pkg::status_t status_reg, status_next;

    logic [tqd_pkg::CFG_W-1:0]    aw_reg;
    logic [NW-1:0]                n_reg, n_next, n_calc;
    logic                         mode_reg, mode_next;
    logic [tqd_pkg::WORKER_W-1:0] w_reg, w_next;
    logic [SW-1:0]                pay_reg, pay_next;
    logic [QW-1:0]                v_reg, v_next, v_inc, best_new;
    logic [QW-1:0]                best_reg, best_next;
    logic [NW-1:0]                i_reg, i_next;
    logic [tqd_pkg::WORKER_W-1:0] qidx_reg, qidx_next;
    logic                         stolen_reg, stolen_next;
    logic [SW-1:0]                task_reg, task_next;
    logic                         last_scan;

    logic [FW-1:0] fill_reg [MAX_WORKERS];
    logic [FW-1:0] fill_next [MAX_WORKERS];
    logic [PW-1:0] rp_reg [MAX_WORKERS];
    logic [PW-1:0] rp_next [MAX_WORKERS];
    logic [PW-1:0] wp_reg [MAX_WORKERS];
    logic [PW-1:0] wp_next [MAX_WORKERS];

    logic                         out_valid_reg, out_valid_next;
    tqd_pkg::status_t             out_status_reg, out_status_next;
    logic [tqd_pkg::WORKER_W-1:0] out_qidx_reg, out_qidx_next;
    logic [tqd_pkg::TASK_W-1:0]   out_task_reg, out_task_next;
    logic                         out_stolen_reg, out_stolen_next;

    logic          ram_we;
    logic [AW-1:0] ram_addr;
    logic [SW-1:0] ram_rdata;

    tqd_ram #(
        .WIDTH (SW),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (pay_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        if (aw_reg == '0)
        begin
            n_calc = NW'(1);
        end
        else if (8'(aw_reg) > 8'(MAX_WORKERS))
        begin
            n_calc = NW'(MAX_WORKERS);
        end
        else
        begin
            n_calc = NW'(aw_reg);
        end
    end

    assign req.ready      = (state_reg == tqd_pkg::FSM_READY);
    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.queue_index = out_qidx_reg;
    assign rsp.task_out   = out_task_reg;
    assign rsp.stolen     = out_stolen_reg;

    always_comb
    begin
        state_next      = state_reg;
        status_next     = status_reg;
        n_next          = n_reg;
        mode_next       = mode_reg;
        w_next          = w_reg;
        pay_next        = pay_reg;
        v_next          = v_reg;
        best_next       = best_reg;
        i_next          = i_reg;
        qidx_next       = qidx_reg;
        stolen_next     = stolen_reg;
        task_next       = task_reg;
        fill_next       = fill_reg;
        rp_next         = rp_reg;
        wp_next         = wp_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_qidx_next   = out_qidx_reg;
        out_task_next   = out_task_reg;
        out_stolen_next = out_stolen_reg;
        ram_we          = 1'b0;
        ram_addr        = AW'(v_reg) * AW'(QUEUE_DEPTH) + AW'(rp_reg[v_reg]);

        last_scan = ((i_reg + NW'(1)) == n_reg);
        v_inc     = ((NW'(v_reg) + NW'(1)) == n_reg) ? '0 : (v_reg + QW'(1));
        best_new  = (fill_reg[v_reg] < fill_reg[best_reg]) ? v_reg : best_reg;

        case (state_reg)
            tqd_pkg::FSM_READY:
            begin
                if (req.valid)
                begin
                    n_next      = n_calc;
                    mode_next   = req.mode;
                    w_next      = req.worker_id;
                    pay_next    = SW'(req.task_payload);
                    i_next      = '0;
                    best_next   = '0;
                    stolen_next = 1'b0;
                    task_next   = '0;
                    qidx_next   = req.worker_id;
                    if (req.mode == tqd_pkg::MODE_SUBMIT)
                    begin
                        v_next     = '0;
                        state_next = tqd_pkg::FSM_SCAN;
                    end
                    else if (8'(req.worker_id) >= 8'(n_calc))
                    begin
                        status_next = tqd_pkg::ST_BAD_WORKER;
                        qidx_next   = '0;
                        state_next  = tqd_pkg::FSM_DONE;
                    end
                    else
                    begin
                        v_next     = QW'(req.worker_id);
                        state_next = tqd_pkg::FSM_SCAN;
                    end
                end
            end
            tqd_pkg::FSM_SCAN:
            begin
                if (mode_reg == tqd_pkg::MODE_SUBMIT)
                begin
                    best_next = best_new;
                    if (last_scan)
                    begin
                        state_next = tqd_pkg::FSM_DONE;
                        if (fill_reg[best_new] >= FW'(QUEUE_DEPTH))
                        begin
                            status_next = tqd_pkg::ST_OVERFLOW;
                            qidx_next   = '0;
                        end
                        else
                        begin
                            ram_we   = 1'b1;
                            ram_addr = AW'(best_new) * AW'(QUEUE_DEPTH)
                                     + AW'(wp_reg[best_new]);
                            wp_next[best_new]   = (wp_reg[best_new] == PW'(QUEUE_DEPTH - 1))
                                                ? '0 : (wp_reg[best_new] + PW'(1));
                            fill_next[best_new] = fill_reg[best_new] + FW'(1);
                            status_next = tqd_pkg::ST_QUEUED;
                            qidx_next   = tqd_pkg::WORKER_W'(best_new);
                        end
                    end
                    else
                    begin
                        v_next = v_reg + QW'(1);
                        i_next = i_reg + NW'(1);
                    end
                end
                else if (fill_reg[v_reg] != '0)
                begin
                    rp_next[v_reg]   = (rp_reg[v_reg] == PW'(QUEUE_DEPTH - 1))
                                     ? '0 : (rp_reg[v_reg] + PW'(1));
                    fill_next[v_reg] = fill_reg[v_reg] - FW'(1);
                    status_next = tqd_pkg::ST_DELIVERED;
                    qidx_next   = tqd_pkg::WORKER_W'(v_reg);
                    stolen_next = (i_reg != '0);
                    state_next  = tqd_pkg::FSM_READ;
                end
                else if (last_scan)
                begin
                    status_next = tqd_pkg::ST_IDLE;
                    qidx_next   = w_reg;
                    state_next  = tqd_pkg::FSM_DONE;
                end
                else
                begin
                    v_next = v_inc;
                    i_next = i_reg + NW'(1);
                end
            end
            tqd_pkg::FSM_READ:
            begin
                task_next  = ram_rdata;
                state_next = tqd_pkg::FSM_DONE;
            end
            tqd_pkg::FSM_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_qidx_next   = qidx_reg;
                    out_task_next   = tqd_pkg::TASK_W'(task_reg);
                    out_stolen_next = stolen_reg;
                    state_next      = tqd_pkg::FSM_READY;
                end
            end
            default:
            begin
                state_next = tqd_pkg::FSM_READY;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tqd_pkg::FSM_READY;
            aw_reg        <= tqd_pkg::ACTIVE_RESET;
            out_valid_reg <= 1'b0;
            for (int q = 0; q < MAX_WORKERS; q++)
            begin
                fill_reg[q] <= '0;
                rp_reg[q]   <= '0;
                wp_reg[q]   <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            fill_reg      <= fill_next;
            rp_reg        <= rp_next;
            wp_reg        <= wp_next;
            if (cfg_we)
            begin
                aw_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg     <= status_next;
        n_reg          <= n_next;
        mode_reg       <= mode_next;
        w_reg          <= w_next;
        pay_reg        <= pay_next;
        v_reg          <= v_next;
        best_reg       <= best_next;
        i_reg          <= i_next;
        qidx_reg       <= qidx_next;
        stolen_reg     <= stolen_next;
        task_reg       <= task_next;
        out_status_reg <= out_status_next;
        out_qidx_reg   <= out_qidx_next;
        out_task_reg   <= out_task_next;
        out_stolen_reg <= out_stolen_next;
    end

endmodule

>>> sv/tqd_checker.sv
// Port-level assertions of the task queue dispatcher and their bind.
module tqd_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [tqd_pkg::STATUS_W-1:0] rsp_status,
    input logic [tqd_pkg::WORKER_W-1:0] rsp_queue_index,
    input logic [tqd_pkg::TASK_W-1:0]   rsp_task_out,
    input logic                         rsp_stolen
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
            && $stable(rsp_queue_index) && $stable(rsp_task_out) && $stable(rsp_stolen))
        else $error("stalled result changed");

    a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status != tqd_pkg::ST_DELIVERED)
            |-> (rsp_task_out == '0) && !rsp_stolen)
        else $error("task_out or stolen set without delivery");

    a_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && ((rsp_status == tqd_pkg::ST_OVERFLOW)
            || (rsp_status == tqd_pkg::ST_BAD_WORKER)) |-> (rsp_queue_index == '0))
        else $error("queue_index not zero on overflow or bad worker");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request accepted while another is in progress");

endmodule

bind task_queue_dispatch_steal tqd_checker u_tqd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_queue_index (rsp.queue_index),
    .rsp_task_out    (rsp.task_out),
    .rsp_stolen      (rsp.stolen)
);
